// ----- rtl/core/positional_insert_delete_list_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the positional insert/delete list
// Clocked property checks on clk, with and without the reset qualifier.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_INSERT_DELETE_LIST_MACROS_SVH
`define POSITIONAL_INSERT_DELETE_LIST_MACROS_SVH

// check while out of reset
`define PIDL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also covers the reset cycles
`define PIDL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/pidl_pkg.sv -----
// ---------------------------------------------------------------------------
// pidl_pkg
// Shared constants, request and status codes and the cell command type.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pidl_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int VAL_W = 32;
  localparam int POS_W = 5;
  localparam int CNT_OUT_W = 5;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [1:0] PLACE_AT = 2'd0;
  localparam logic [1:0] PLACE_FRONT = 2'd1;
  localparam logic [1:0] PLACE_END = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  localparam logic [VAL_W-1:0] NEG_ONE = {VAL_W{1'b1}};

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_cmd_t;

endpackage

// ----- rtl/core/pidl_cell.sv -----
// ---------------------------------------------------------------------------
// pidl_cell
// One list slot: holds one entry, takes its left or right neighbor on a
// shift, loads the new value at the target and offers its entry for readout.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pidl_cell #(
  parameter int IDX_W = 4,
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  pidl_pkg::cell_cmd_t         cmd,
  input  logic [IDX_W-1:0]            target,
  input  logic [pidl_pkg::VAL_W-1:0]  value,
  input  logic [pidl_pkg::VAL_W-1:0]  left_data,
  input  logic [pidl_pkg::VAL_W-1:0]  right_data,
  output logic [pidl_pkg::VAL_W-1:0]  data,
  output logic [pidl_pkg::VAL_W-1:0]  tap
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [pidl_pkg::VAL_W-1:0] data_r;
  logic [pidl_pkg::VAL_W-1:0] data_nxt;
  logic                       hit;
  logic                       above;

  assign hit = (MY_IDX == target);
  assign above = (MY_IDX > target);

  always_comb begin
    data_nxt = data_r;
    if (cmd.ins && hit) begin
      data_nxt = value;
    end else if (cmd.ins && above) begin
      data_nxt = left_data;
    end else if (cmd.rem && (hit || above)) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  assign tap = hit ? data_r : '0;

endmodule

// ----- rtl/core/positional_insert_delete_list.sv -----
// ---------------------------------------------------------------------------
// positional_insert_delete_list
// Fixed-capacity packed list of signed words with insert and remove at the
// front, the end or a given position, built as a row of shifting cells.
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | action, place, position, value
//  out_    | output    | out_valid/out_stall | removed_value, status, entry_count
//
//  One item per cycle while in_stall is low: every cell shifts or loads in
//  parallel in the cycle the item is accepted, and its result lands in the
//  output register. The result appears in the cycle after acceptance.
//  Reset empties the list and the output register; entries are not cleared.
//  in_stall rises only while a result is held and out_stall is high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "positional_insert_delete_list_macros.svh"

module positional_insert_delete_list #(
  parameter int CAPACITY = pidl_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_action,
  input  logic [1:0]                        in_place,
  input  logic [pidl_pkg::POS_W-1:0]        in_position,
  input  logic signed [pidl_pkg::VAL_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [pidl_pkg::VAL_W-1:0] out_removed_value,
  output logic [1:0]                        out_status,
  output logic [pidl_pkg::CNT_OUT_W-1:0]    out_entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int TW = $clog2(CAPACITY);
  localparam int KW = (CW > pidl_pkg::POS_W) ? CW : pidl_pkg::POS_W;

  logic                       in_acc;
  logic [CW-1:0]              count_r;
  logic [CW-1:0]              count_nxt;
  logic [KW-1:0]              cnt_k;
  logic [KW-1:0]              tgt_k;
  logic [KW-1:0]              cnt_nxt_k;
  logic                       place_ok;
  logic                       is_full;
  logic                       is_empty;
  logic [1:0]                 st;
  logic                       do_op;
  pidl_pkg::cell_cmd_t        cmd;
  logic [pidl_pkg::VAL_W-1:0] taps_or;
  logic [pidl_pkg::VAL_W-1:0] result;

  logic [pidl_pkg::VAL_W-1:0] cell_data [CAPACITY];
  logic [pidl_pkg::VAL_W-1:0] cell_tap [CAPACITY];

  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic [pidl_pkg::VAL_W-1:0]    out_value_r;
  logic [1:0]                    out_status_r;
  logic [pidl_pkg::CNT_OUT_W-1:0] out_count_r;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc = in_valid && !in_stall;

  assign cnt_k = KW'(count_r);
  assign is_full = (count_r == CW'(CAPACITY));
  assign is_empty = (count_r == '0);

  always_comb begin
    place_ok = 1'b1;
    tgt_k = '0;
    case (in_place)
      pidl_pkg::PLACE_AT: begin
        tgt_k = KW'(in_position);
      end
      pidl_pkg::PLACE_FRONT: begin
        tgt_k = '0;
      end
      pidl_pkg::PLACE_END: begin
        tgt_k = (in_action == pidl_pkg::ACT_INSERT) ? cnt_k : cnt_k - KW'(1);
      end
      default: begin
        place_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    st = pidl_pkg::ST_OK;
    if (in_action == pidl_pkg::ACT_INSERT) begin
      if (is_full) begin
        st = pidl_pkg::ST_FULL;
      end else if (!place_ok || (tgt_k > cnt_k)) begin
        st = pidl_pkg::ST_BADPOS;
      end
    end else begin
      if (is_empty) begin
        st = pidl_pkg::ST_EMPTY;
      end else if (!place_ok || (tgt_k >= cnt_k)) begin
        st = pidl_pkg::ST_BADPOS;
      end
    end
  end

  assign do_op = in_acc && (st == pidl_pkg::ST_OK);
  assign cmd = '{ins: do_op && (in_action == pidl_pkg::ACT_INSERT),
                 rem: do_op && (in_action == pidl_pkg::ACT_REMOVE)};

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [pidl_pkg::VAL_W-1:0] left_w;
      logic [pidl_pkg::VAL_W-1:0] right_w;

      if (g == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_mid_l
        assign left_w = cell_data[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
        assign right_w = '0;
      end else begin : g_mid_r
        assign right_w = cell_data[g+1];
      end

      pidl_cell #(
        .IDX_W(TW),
        .IDX  (g)
      ) u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .target    (tgt_k[TW-1:0]),
        .value     (in_value),
        .left_data (left_w),
        .right_data(right_w),
        .data      (cell_data[g]),
        .tap       (cell_tap[g])
      );
    end
  endgenerate

  always_comb begin
    taps_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      taps_or = taps_or | cell_tap[i];
    end
  end

  always_comb begin
    if (in_action == pidl_pkg::ACT_INSERT) begin
      result = '0;
    end else if (st == pidl_pkg::ST_OK) begin
      result = taps_or;
    end else begin
      result = pidl_pkg::NEG_ONE;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.rem) begin
      count_nxt = count_r - CW'(1);
    end
  end

  assign cnt_nxt_k = KW'(count_nxt);

  always_comb begin
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_value_r <= result;
      out_status_r <= st;
      out_count_r <= cnt_nxt_k[pidl_pkg::CNT_OUT_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_removed_value = out_value_r;
  assign out_status = out_status_r;
  assign out_entry_count = out_count_r;

  `PIDL_ASSERT(a_count_bound, count_r <= CW'(CAPACITY), "entry count above capacity")
  `PIDL_ASSERT(a_insert_grows, cmd.ins |=> count_r == $past(count_r) + CW'(1), "insert did not grow list")
  `PIDL_ASSERT(a_no_op_holds, (in_acc && (st != pidl_pkg::ST_OK)) |=> $stable(count_r), "failed item changed count")
  `PIDL_ASSERT_RST(a_reset_empty, !rst_n |=> (!out_valid_r && (count_r == '0)), "reset left state behind")

endmodule
